FILE: design/pltc_pkg.sv
// Package for the piecewise linear temperature correction block.
// Holds widths, codes, item types and the nominal calibration points.
// No dependencies.
`default_nettype none
package pltc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int VAL_W        = 16;
  localparam int NPOINTS      = 7;
  localparam int NSEG         = 6;
  localparam int XW           = ((SAMPLE_WIDTH > VAL_W) ? SAMPLE_WIDTH : VAL_W) + 1;
  localparam int DW           = VAL_W + 1;
  localparam int PW           = DW + XW;
  localparam int QW           = PW - 1;
  localparam int RW           = QW + 2;
  localparam int LOW_LIMIT    = 3000;
  localparam int HIGH_LIMIT   = 10500;

  typedef logic [1:0]                     action_t;
  typedef logic [2:0]                     idx_t;
  typedef logic [1:0]                     status_t;
  typedef logic signed [VAL_W-1:0]        val_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  localparam action_t ACT_CORRECT = 2'd0;
  localparam action_t ACT_WREF    = 2'd1;
  localparam action_t ACT_WFIX    = 2'd2;
  localparam action_t ACT_RSVD    = 2'd3;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_PASS = 2'd1;
  localparam status_t ST_ZERO = 2'd2;
  localparam status_t ST_SAT  = 2'd3;

  function automatic val_t nominal(input idx_t i);
    val_t v;
    unique case (i)
      3'd0:    v = 16'sd10500;
      3'd1:    v = 16'sd9500;
      3'd2:    v = 16'sd9000;
      3'd3:    v = 16'sd7000;
      3'd4:    v = 16'sd6000;
      3'd5:    v = 16'sd5000;
      default: v = 16'sd3000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: design/pltc_in_if.sv
// Request channel of the temperature correction block.
// Depends on pltc_pkg.
`default_nettype none
interface pltc_in_if;
  logic              valid;
  logic              ready;
  pltc_pkg::action_t action;
  pltc_pkg::idx_t    entry_index;
  pltc_pkg::val_t    entry_value;
  pltc_pkg::sample_t sample_in;
  modport source (output valid, action, entry_index, entry_value, sample_in, input ready);
  modport sink   (input valid, action, entry_index, entry_value, sample_in, output ready);
endinterface
`default_nettype wire

FILE: design/pltc_out_if.sv
// Result channel of the temperature correction block.
// Depends on pltc_pkg.
`default_nettype none
interface pltc_out_if;
  logic              valid;
  logic              ready;
  pltc_pkg::sample_t corrected;
  pltc_pkg::idx_t    segment;
  pltc_pkg::status_t status;
  modport source (output valid, corrected, segment, status, input ready);
  modport sink   (input valid, corrected, segment, status, output ready);
endinterface
`default_nettype wire

FILE: design/piecewise_linear_temp_correction.sv
// Top level of the piecewise linear temperature correction block.
// Depends on pltc_pkg, pltc_in_if and pltc_out_if.
`default_nettype none
// One request enters per cycle while no result waits to be taken, table writes and
// corrections alike; a correction of a 16-bit sample passes the table read,
// difference and product stages, then the restoring divider that retires one
// quotient bit per stage. The whole pipeline holds while a finished result waits
// to be taken. Table writes take effect for the next request. Both tables start
// at the nominal points, so out of reset the correction is an identity.
module piecewise_linear_temp_correction (
  input  wire logic clk,
  input  wire logic rst_n,
  pltc_in_if.sink   in_chan,
  pltc_out_if.source out_chan
);
  import pltc_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam logic signed [RW-1:0] MAXV = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

  logic en, acc;
  assign en  = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;
  assign acc = in_chan.valid && en;

  // tables: memories with valid bits, unwritten entries read as nominal
  val_t ref_mem [NPOINTS];
  val_t fix_mem [NPOINTS];
  logic [NPOINTS-1:0] ref_ok_r, fix_ok_r;

  // stage 0: segment select
  logic signed [XW-1:0] samp_x;
  logic inr_c;
  idx_t seg_c, seg_hi_c;
  always_comb begin
    samp_x = XW'(in_chan.sample_in);
    inr_c  = (samp_x >= XW'(LOW_LIMIT)) && (samp_x <= XW'(HIGH_LIMIT));
    seg_c  = idx_t'(NSEG - 1);
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (samp_x >= XW'(nominal(idx_t'(i + 1)))) seg_c = idx_t'(i);
    end
    seg_hi_c = seg_c + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_ok_r <= '0;
      fix_ok_r <= '0;
    end else if (acc && in_chan.entry_index < idx_t'(NPOINTS)) begin
      if (in_chan.action == ACT_WREF) begin
        ref_mem[in_chan.entry_index] <= in_chan.entry_value;
        ref_ok_r[in_chan.entry_index] <= 1'b1;
      end
      if (in_chan.action == ACT_WFIX) begin
        fix_mem[in_chan.entry_index] <= in_chan.entry_value;
        fix_ok_r[in_chan.entry_index] <= 1'b1;
      end
    end
  end

  // stage 1: registered table reads
  logic s1_vld_r, s1_inr_r;
  idx_t s1_seg_r;
  sample_t s1_samp_r;
  val_t ylo_r, yhi_r, xlo_r, xhi_r;
  logic ylo_ok_r, yhi_ok_r, xlo_ok_r, xhi_ok_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= acc && in_chan.action == ACT_CORRECT;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_inr_r  <= inr_c;
      s1_seg_r  <= seg_c;
      s1_samp_r <= in_chan.sample_in;
      ylo_r     <= ref_mem[seg_c];
      yhi_r     <= ref_mem[seg_hi_c];
      xlo_r     <= fix_mem[seg_c];
      xhi_r     <= fix_mem[seg_hi_c];
      ylo_ok_r  <= ref_ok_r[seg_c];
      yhi_ok_r  <= ref_ok_r[seg_hi_c];
      xlo_ok_r  <= fix_ok_r[seg_c];
      xhi_ok_r  <= fix_ok_r[seg_hi_c];
    end
  end

  // stage 2: differences
  val_t y0_c, y1_c, x0_c, x1_c;
  always_comb begin
    y0_c = ylo_ok_r ? ylo_r : nominal(s1_seg_r);
    y1_c = yhi_ok_r ? yhi_r : nominal(s1_seg_r + 3'd1);
    x0_c = xlo_ok_r ? xlo_r : nominal(s1_seg_r);
    x1_c = xhi_ok_r ? xhi_r : nominal(s1_seg_r + 3'd1);
  end

  logic s2_vld_r, s2_inr_r;
  idx_t s2_seg_r;
  sample_t s2_samp_r;
  val_t s2_y0_r;
  logic signed [DW-1:0] s2_dy_r, s2_span_r;
  logic signed [XW-1:0] s2_dx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_inr_r  <= s1_inr_r;
      s2_seg_r  <= s1_seg_r;
      s2_samp_r <= s1_samp_r;
      s2_y0_r   <= y0_c;
      s2_dy_r   <= DW'(y1_c) - DW'(y0_c);
      s2_span_r <= DW'(x1_c) - DW'(x0_c);
      s2_dx_r   <= XW'(s1_samp_r) - XW'(x0_c);
    end
  end

  // stage 3: product
  logic s3_vld_r, s3_inr_r;
  idx_t s3_seg_r;
  sample_t s3_samp_r;
  val_t s3_y0_r;
  logic signed [DW-1:0] s3_span_r;
  logic signed [PW-1:0] s3_prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (en) s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_inr_r  <= s2_inr_r;
      s3_seg_r  <= s2_seg_r;
      s3_samp_r <= s2_samp_r;
      s3_y0_r   <= s2_y0_r;
      s3_span_r <= s2_span_r;
      s3_prod_r <= PW'(s2_dy_r) * PW'(s2_dx_r);
    end
  end

  // divider: magnitudes in, one quotient bit per stage
  logic signed [PW-1:0] pabs_c;
  logic signed [DW-1:0] sabs_c;
  assign pabs_c = s3_prod_r[PW-1] ? -s3_prod_r : s3_prod_r;
  assign sabs_c = s3_span_r[DW-1] ? -s3_span_r : s3_span_r;

  logic    d_vld_r  [QW+1];
  logic    d_inr_r  [QW+1];
  logic    d_neg_r  [QW+1];
  logic    d_zero_r [QW+1];
  idx_t    d_seg_r  [QW+1];
  sample_t d_samp_r [QW+1];
  val_t    d_y0_r   [QW+1];
  logic [DW-2:0] d_den_r [QW+1];
  logic [DW-2:0] d_rem_r [QW+1];
  logic [QW-1:0] d_num_r [QW+1];
  logic [DW-2:0] rem_nxt [QW];
  logic [QW-1:0] num_nxt [QW];

  always_comb begin
    logic [DW-1:0] trial;
    logic ge;
    for (int k = 0; k < QW; k++) begin
      trial = {d_rem_r[k], d_num_r[k][QW-1]};
      ge    = trial >= {1'b0, d_den_r[k]};
      rem_nxt[k] = ge ? (DW-1)'(trial - {1'b0, d_den_r[k]}) : trial[DW-2:0];
      num_nxt[k] = {d_num_r[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) d_vld_r[k] <= 1'b0;
    end else if (en) begin
      d_vld_r[0] <= s3_vld_r;
      for (int k = 0; k < QW; k++) d_vld_r[k+1] <= d_vld_r[k];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_inr_r[0]  <= s3_inr_r;
      d_neg_r[0]  <= s3_prod_r[PW-1] ^ s3_span_r[DW-1];
      d_zero_r[0] <= s3_span_r == '0;
      d_seg_r[0]  <= s3_seg_r;
      d_samp_r[0] <= s3_samp_r;
      d_y0_r[0]   <= s3_y0_r;
      d_den_r[0]  <= sabs_c[DW-2:0];
      d_rem_r[0]  <= '0;
      d_num_r[0]  <= pabs_c[QW-1:0];
      for (int k = 0; k < QW; k++) begin
        d_inr_r[k+1]  <= d_inr_r[k];
        d_neg_r[k+1]  <= d_neg_r[k];
        d_zero_r[k+1] <= d_zero_r[k];
        d_seg_r[k+1]  <= d_seg_r[k];
        d_samp_r[k+1] <= d_samp_r[k];
        d_y0_r[k+1]   <= d_y0_r[k];
        d_den_r[k+1]  <= d_den_r[k];
        d_rem_r[k+1]  <= rem_nxt[k];
        d_num_r[k+1]  <= num_nxt[k];
      end
    end
  end

  // final: sign, offset, zero-span fallback, saturate, out-of-range pass-through
  logic signed [RW-1:0] q_c, sum_c;
  sample_t corr_c;
  idx_t seg_o_c;
  status_t st_c;
  always_comb begin
    q_c   = {2'b00, d_num_r[QW]};
    if (d_neg_r[QW]) q_c = -q_c;
    sum_c = RW'(d_y0_r[QW]) + q_c;
    st_c  = ST_OK;
    if (d_zero_r[QW]) begin
      sum_c = RW'(d_y0_r[QW]);
      st_c  = ST_ZERO;
    end
    if (sum_c > MAXV) begin
      sum_c = MAXV;
      st_c  = ST_SAT;
    end else if (sum_c < MINV) begin
      sum_c = MINV;
      st_c  = ST_SAT;
    end
    corr_c  = sum_c[SW-1:0];
    seg_o_c = d_seg_r[QW];
    if (!d_inr_r[QW]) begin
      corr_c  = d_samp_r[QW];
      seg_o_c = '0;
      st_c    = ST_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_chan.valid <= 1'b0;
    else if (en) out_chan.valid <= d_vld_r[QW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_chan.corrected <= corr_c;
      out_chan.segment   <= seg_o_c;
      out_chan.status    <= st_c;
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for piecewise_linear_temp_correction: directed table, then random requests.
// Predicts corrections from its copies of both tables unless the row gives the result.
// Depends on pltc_pkg, pltc_in_if, pltc_out_if and the RTL.
`default_nettype none
module tb;
  import pltc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = QW + 4;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    sample_t corrected;
    idx_t    segment;
    status_t status;
  } correction_t;

  typedef struct packed {
    action_t action;
    idx_t    entry_index;
    val_t    entry_value;
    sample_t sample_in;
    logic    has_exp;
    correction_t exp_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  pltc_in_if  in_chan ();
  pltc_out_if out_chan ();

  piecewise_linear_temp_correction u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  val_t ref_pts [NPOINTS];
  val_t fix_pts [NPOINTS];
  correction_t pending_corrections[$];
  int unsigned err_count = 0;
  int unsigned idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold = 1'b0;

  function automatic int nominal_pt(input int i);
    case (i)
      0: return 10500;
      1: return 9500;
      2: return 9000;
      3: return 7000;
      4: return 6000;
      5: return 5000;
      default: return 3000;
    endcase
  endfunction

  function automatic correction_t predict_correction(input sample_t x);
    correction_t r;
    longint xs, x0, x1, y0, y1, span, res;
    int seg;
    xs = x;
    seg = 0;
    r.segment = '0;
    if (xs < LOW_LIMIT || xs > HIGH_LIMIT) begin
      r.corrected = x;
      r.status = ST_PASS;
      return r;
    end
    while (seg < NPOINTS - 2 && xs < nominal_pt(seg + 1)) seg++;
    x0 = fix_pts[seg];
    x1 = fix_pts[seg + 1];
    y0 = ref_pts[seg];
    y1 = ref_pts[seg + 1];
    span = x1 - x0;
    if (span == 0) begin
      res = y0;
      r.status = ST_ZERO;
    end else begin
      res = y0 + ((y1 - y0) * (xs - x0)) / span;
      r.status = ST_OK;
    end
    if (res > 32767) begin
      res = 32767;
      r.status = ST_SAT;
    end else if (res < -32768) begin
      res = -32768;
      r.status = ST_SAT;
    end
    r.corrected = sample_t'(res);
    r.segment = idx_t'(seg);
    return r;
  endfunction

  // Update the table copies and queue the expected result for one accepted request.
  function automatic void apply_request(input stim_row_t row);
    if (row.action == ACT_WREF && row.entry_index < NPOINTS)
      ref_pts[row.entry_index] = row.entry_value;
    else if (row.action == ACT_WFIX && row.entry_index < NPOINTS)
      fix_pts[row.entry_index] = row.entry_value;
    else if (row.action == ACT_CORRECT) begin
      if (row.has_exp) pending_corrections.push_back(row.exp_res);
      else pending_corrections.push_back(predict_correction(row.sample_in));
    end
  endfunction

  function automatic stim_row_t mk(input action_t a, input int idx, input int v, input int s);
    stim_row_t row;
    row.action = a;
    row.entry_index = idx_t'(idx);
    row.entry_value = val_t'(v);
    row.sample_in = sample_t'(s);
    row.has_exp = 1'b0;
    row.exp_res = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_exp(input int s, input int c, input int seg, input status_t st);
    stim_row_t row;
    row = mk(ACT_CORRECT, 0, 0, s);
    row.has_exp = 1'b1;
    row.exp_res.corrected = sample_t'(c);
    row.exp_res.segment = idx_t'(seg);
    row.exp_res.status = st;
    return row;
  endfunction

  // Check results at the rising edge.
  always @(posedge clk) begin
    correction_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_corrections.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result %0d", out_chan.corrected);
      end else begin
        e = pending_corrections.pop_front();
        if (e.corrected !== out_chan.corrected || e.segment !== out_chan.segment ||
            e.status !== out_chan.status) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d", e.corrected, e.segment,
                     e.status, out_chan.corrected, out_chan.segment, out_chan.status);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input stim_row_t row);
    in_chan.action <= row.action;
    in_chan.entry_index <= row.entry_index;
    in_chan.entry_value <= row.entry_value;
    in_chan.sample_in <= row.sample_in;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    apply_request(row);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_corrections.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic stim_row_t random_row();
    int k;
    int s;
    k = $urandom_range(99);
    if (k < 70) begin
      s = (k < 55) ? $urandom_range(HIGH_LIMIT, LOW_LIMIT) : $urandom_range(65535);
      if (k == 0) s = LOW_LIMIT;
      return mk(ACT_CORRECT, 0, 0, s);
    end else if (k < 95) begin
      // Near-nominal values mostly, full range sometimes for saturation.
      s = ($urandom_range(3) == 0) ? $urandom_range(65535) - 32768
                                    : nominal_pt(0) - $urandom_range(8000);
      return mk(k < 83 ? ACT_WREF : ACT_WFIX, $urandom_range(7), s, $urandom);
    end
    return mk(ACT_RSVD, $urandom_range(7), $urandom, $urandom);
  endfunction

  initial begin
    stim_row_t directed [$];
    stim_row_t row;
    int sent;
    in_chan.valid = 1'b0;
    in_chan.action = ACT_CORRECT;
    in_chan.entry_index = '0;
    in_chan.entry_value = '0;
    in_chan.sample_in = '0;
    for (int i = 0; i < NPOINTS; i++) begin
      ref_pts[i] = val_t'(nominal_pt(i));
      fix_pts[i] = val_t'(nominal_pt(i));
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identity out of reset, range edges, pass-through extremes.
    directed.push_back(mk_exp(10500, 10500, 0, ST_OK));
    directed.push_back(mk_exp(3000, 3000, 5, ST_OK));
    directed.push_back(mk_exp(9499, 9499, 1, ST_OK));
    directed.push_back(mk_exp(2999, 2999, 0, ST_PASS));
    directed.push_back(mk_exp(10501, 10501, 0, ST_PASS));
    directed.push_back(mk_exp(-32768, -32768, 0, ST_PASS));
    directed.push_back(mk_exp(32767, 32767, 0, ST_PASS));
    // Zero span on segment 3.
    directed.push_back(mk(ACT_WFIX, 3, 6000, 0));
    directed.push_back(mk(ACT_CORRECT, 0, 0, 6500));
    directed.push_back(mk(ACT_WFIX, 3, 7000, 0));
    // Saturate low on segment 0.
    directed.push_back(mk(ACT_WREF, 1, -32768, 0));
    directed.push_back(mk(ACT_WREF, 0, 32767, 0));
    directed.push_back(mk(ACT_WFIX, 1, 10499, 0));
    directed.push_back(mk(ACT_CORRECT, 0, 0, 9500));
    directed.push_back(mk(ACT_CORRECT, 0, 0, 10000));
    // Ignored requests: index 7 and the reserved action.
    directed.push_back(mk(ACT_WREF, 7, 123, 0));
    directed.push_back(mk(ACT_RSVD, 5, -1, -1));
    directed.push_back(mk(ACT_WREF, 0, 10500, 0));
    directed.push_back(mk(ACT_WREF, 1, 9500, 0));
    directed.push_back(mk(ACT_WFIX, 1, 9500, 0));
    directed.push_back(mk(ACT_CORRECT, 0, 0, 5000));
    foreach (directed[i]) send_request(directed[i]);
    drain();

    // Four idling phases, random requests.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 47 : 28) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 47 : 28) : 0;
      if (ph == 0) fork
        begin
          long_hold = 1'b1;
          repeat (300) @(negedge clk);
          long_hold = 1'b0;
        end
      join_none
      sent = 0;
      while (sent < 112) begin
        row = random_row();
        send_request(row);
        sent++;
      end
      drain();
    end

    if (err_count == 0 && pending_corrections.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
design/pltc_pkg.sv
design/pltc_in_if.sv
design/pltc_out_if.sv
design/piecewise_linear_temp_correction.sv
dv/tb.sv
